// ===== rtl/ssp_arb_pkg.sv =====
// shared types and constants for the source priority arbiter
package ssp_arb_pkg;

  localparam int SourceSlotsDefault = 4;
  localparam logic [15:0] TimeoutReset = 16'd2500;
  localparam logic [15:0] HoldReset = 16'd2500;
  localparam logic [7:0] PriorityMax = 8'd255;

  typedef enum logic [3:0] {
    KIND_ACCEPT       = 4'd0,
    KIND_DROP_LOW     = 4'd1,
    KIND_DROP_EXCEED  = 4'd2,
    KIND_DROP_HOLD    = 4'd3,
    KIND_TERMINATED   = 4'd4,
    KIND_TERM_UNKNOWN = 4'd5,
    KIND_LOST_PRIO    = 4'd6,
    KIND_LOST_TIMEOUT = 4'd7,
    KIND_TICK_DONE    = 4'd8
  } kind_t;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_HOLD    = 1'b1
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DEC   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_MARKS = 6'b100000
  } state_t;

  // slot record held in the table memory
  typedef struct packed {
    logic        valid;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [7:0]  prio;
    logic [15:0] timer;
  } entry_t;

endpackage

// ===== rtl/stream_source_priority_arbiter.sv =====
// top level of the source priority arbiter
//
// start with busy low takes one beat: a packet (req_type 0) or a tick
// (req_type 1). results come out on result_kind, slot, slot_id_high,
// slot_id_low, new_source and notify_exceeded, one beat per cycle marked by
// done; last marks the final beat of an item. the receiver cannot stall.
// slot state lives in a one-port-read table memory; the items are worked
// one at a time: a packet scan reads each slot once, then the packet
// writes at most one slot; a tick walks every slot with a read, modify
// and write pass. a packet below the low mark is answered on the next
// cycle and leaves busy low. busy stays high until the last beat and,
// unless a packet is dropped after its scan, a final pass that
// recomputes the low and high marks from the table. reset clears control
// state and walks the table to invalidate every slot, with busy held
// high. configuration is taken on the APB port at 0 (source timeout)
// and 4 (hold ticks); the user must write it only between items, as the
// block itself does not enforce it.
module stream_source_priority_arbiter import ssp_arb_pkg::*; #(
  parameter int SourceSlots = SourceSlotsDefault,
  localparam int AW = (SourceSlots > 1) ? $clog2(SourceSlots) : 1,
  localparam int CW = $clog2(SourceSlots + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [63:0] source_id_high,
  input  logic [63:0] source_id_low,
  input  logic [7:0]  priority_req,
  input  logic        terminate,
  output logic        done,
  output logic [3:0]  result_kind,
  output logic [3:0]  slot,
  output logic [63:0] slot_id_high,
  output logic [63:0] slot_id_low,
  output logic        new_source,
  output logic        notify_exceeded,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state;
  logic [15:0] timeout_ticks, hold_ticks, hold_timer;
  logic [7:0] low_mark, high_mark;
  logic clearing;

  logic        r_term;
  logic [63:0] r_hi, r_lo;
  logic [7:0]  r_pri;

  logic [CW-1:0] idx;
  logic [AW-1:0] rd_idx;
  logic          rd_pend;

  logic mine_f, free_f;
  logic [AW-1:0] mine_s, free_s, lo_s;
  logic [7:0] lo_p, hi_p;
  entry_t lo_e;

  logic [7:0] m_hi, m_lo;
  logic m_free;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  ssp_arb_table #(.SourceSlots(SourceSlots)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign pready = 1'b1;
  assign busy = (state != ST_IDLE) || clearing;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      REG_HOLD:    prdata = {16'd0, hold_ticks};
      default:     prdata = '0;
    endcase
  end

  logic last_idx;
  assign last_idx = (idx == CW'(SourceSlots - 1));
  assign raddr = idx[AW-1:0];
  logic id_eq;
  assign id_eq = (rdata.id_hi == r_hi) && (rdata.id_lo == r_lo);

  logic [15:0] tdec;
  assign tdec = (rdata.timer != 16'd0) ? rdata.timer - 16'd1 : 16'd0;

  // decision values
  logic [AW-1:0] tgt;
  logic tgt_ok, fresh, evict;
  logic [15:0] hold_after;
  always_comb begin
    tgt = mine_s; tgt_ok = 1'b0; fresh = 1'b0; evict = 1'b0;
    hold_after = hold_timer;
    if (!r_term && r_pri >= low_mark) begin
      priority if (mine_f) begin
        tgt_ok = 1'b1;
      end else if (free_f) begin
        tgt = free_s; tgt_ok = 1'b1; fresh = 1'b1;
      end else if (r_pri > lo_p) begin
        tgt = lo_s; tgt_ok = 1'b1; fresh = 1'b1; evict = 1'b1;
      end else if (r_pri >= hi_p) begin
        hold_after = hold_ticks;
      end
    end
  end

  logic emit2;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    we <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      timeout_ticks <= TimeoutReset;
      hold_ticks <= HoldReset;
      hold_timer <= '0;
      low_mark <= '0;
      high_mark <= '0;
      clearing <= 1'b1;
      idx <= '0;
      rd_pend <= 1'b0;
      emit2 <= 1'b0;
      last <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
          REG_HOLD:    hold_ticks <= pwdata[15:0];
          default: ;
        endcase
      end
      if (clearing) begin
        we <= 1'b1;
        waddr <= idx[AW-1:0];
        wdata <= '0;
        idx <= last_idx ? '0 : idx + CW'(1);
        if (last_idx) clearing <= 1'b0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (start) begin
              r_term <= terminate;
              r_hi <= source_id_high; r_lo <= source_id_low;
              r_pri <= priority_req;
              idx <= '0;
              rd_pend <= 1'b0;
              if (!req_type && priority_req < low_mark) begin
                done <= 1'b1; last <= 1'b1;
                result_kind <= KIND_DROP_LOW; slot <= '0;
                slot_id_high <= source_id_high; slot_id_low <= source_id_low;
                new_source <= 1'b0; notify_exceeded <= 1'b0;
              end else begin
                mine_f <= 1'b0; free_f <= 1'b0;
                lo_p <= PriorityMax; hi_p <= '0; lo_s <= '0;
                state <= req_type ? ST_DEC : ST_SCAN;
              end
            end
          end
          ST_SCAN: begin
            // idx addresses the read, rdata returns the previous slot
            rd_pend <= 1'b1;
            rd_idx <= idx[AW-1:0];
            if (rd_pend) begin
              if (!rdata.valid) begin
                if (!free_f) begin free_f <= 1'b1; free_s <= rd_idx; end
              end else if (id_eq) begin
                if (!mine_f) begin mine_f <= 1'b1; mine_s <= rd_idx; end
              end else begin
                if (rdata.prio < lo_p) begin
                  lo_p <= rdata.prio; lo_s <= rd_idx; lo_e <= rdata;
                end
                if (rdata.prio > hi_p) hi_p <= rdata.prio;
              end
            end
            if (rd_pend && rd_idx == AW'(SourceSlots - 1)) begin
              state <= ST_EMIT; rd_pend <= 1'b0; emit2 <= 1'b0;
            end else if (!last_idx) begin
              idx <= idx + CW'(1);
            end
          end
          ST_EMIT: begin
            done <= 1'b1;
            new_source <= 1'b0; notify_exceeded <= 1'b0;
            slot_id_high <= r_hi; slot_id_low <= r_lo; slot <= '0;
            last <= 1'b1;
            state <= ST_MARKS; idx <= '0;
            m_hi <= '0; m_lo <= PriorityMax; m_free <= 1'b0;
            if (r_term) begin
              if (mine_f) begin
                result_kind <= KIND_TERMINATED; slot <= 4'(mine_s);
                we <= 1'b1; waddr <= mine_s; wdata <= '0;
              end else begin
                result_kind <= KIND_TERM_UNKNOWN;
              end
            end else if (evict && !emit2) begin
              result_kind <= KIND_LOST_PRIO; slot <= 4'(lo_s);
              slot_id_high <= lo_e.id_hi; slot_id_low <= lo_e.id_lo;
              last <= 1'b0; emit2 <= 1'b1; state <= ST_EMIT;
            end else if (tgt_ok) begin
              result_kind <= (hold_timer != 0) ? KIND_DROP_HOLD : KIND_ACCEPT;
              slot <= 4'(tgt); new_source <= fresh;
              we <= 1'b1; waddr <= tgt;
              wdata <= '{valid: 1'b1, id_hi: r_hi, id_lo: r_lo, prio: r_pri,
                         timer: timeout_ticks};
            end else if (r_pri < hi_p) begin
              result_kind <= KIND_DROP_LOW;
            end else begin
              result_kind <= KIND_DROP_EXCEED;
              notify_exceeded <= (hold_timer == 0);
              hold_timer <= hold_after;
              state <= ST_IDLE;
            end
            if (!r_term && !tgt_ok) state <= ST_IDLE;
          end
          ST_DEC: begin
            // tick pass: read, age, write back, report releases
            rd_pend <= 1'b1;
            rd_idx <= idx[AW-1:0];
            if (rd_pend && rdata.valid) begin
              we <= 1'b1; waddr <= rd_idx;
              wdata <= rdata;
              wdata.timer <= tdec;
              if (tdec == 16'd0) begin
                wdata.valid <= 1'b0; wdata.prio <= '0;
                done <= 1'b1; last <= 1'b0;
                result_kind <= KIND_LOST_TIMEOUT; slot <= 4'(rd_idx);
                slot_id_high <= rdata.id_hi; slot_id_low <= rdata.id_lo;
                new_source <= 1'b0; notify_exceeded <= 1'b0;
              end
            end
            if (rd_pend && rd_idx == AW'(SourceSlots - 1)) begin
              state <= ST_READ; rd_pend <= 1'b0;
            end else if (!last_idx) begin
              idx <= idx + CW'(1);
            end
          end
          ST_READ: begin
            done <= 1'b1; last <= 1'b1;
            result_kind <= KIND_TICK_DONE; slot <= '0;
            slot_id_high <= '0; slot_id_low <= '0;
            new_source <= 1'b0; notify_exceeded <= 1'b0;
            if (hold_timer != 0) hold_timer <= hold_timer - 16'd1;
            state <= ST_MARKS; idx <= '0;
            m_hi <= '0; m_lo <= PriorityMax; m_free <= 1'b0;
          end
          ST_MARKS: begin
            rd_pend <= 1'b1;
            rd_idx <= idx[AW-1:0];
            if (rd_pend) begin
              if (!rdata.valid) m_free <= 1'b1;
              else begin
                if (rdata.prio > m_hi) m_hi <= rdata.prio;
                if (rdata.prio < m_lo) m_lo <= rdata.prio;
              end
            end
            if (rd_pend && rd_idx == AW'(SourceSlots - 1)) begin
              high_mark <= (rdata.valid && rdata.prio > m_hi) ? rdata.prio : m_hi;
              low_mark <= (m_free || !rdata.valid) ? 8'd0 :
                          ((rdata.prio < m_lo) ? rdata.prio : m_lo);
              state <= ST_IDLE; rd_pend <= 1'b0;
            end else if (!last_idx) begin
              idx <= idx + CW'(1);
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ssp_arb_table.sv =====
// slot table memory, one write port and one registered read port with write forwarding
module ssp_arb_table import ssp_arb_pkg::*; #(
  parameter int SourceSlots = SourceSlotsDefault,
  localparam int AW = (SourceSlots > 1) ? $clog2(SourceSlots) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [SourceSlots];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // a read of the entry being written returns the new data
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
